/* rtl/core/xrd_pkg.sv */
// Shared types, codes and helper functions for the xorshift64 range draw block.
// Standalone package; imported by xrd_ctrl, xrd_dpath and the top level.
`default_nettype none

package xrd_pkg;

    localparam int DATA_W    = 64;
    localparam int SEED_W    = 32;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int XS_SHIFT_A = 13;
    localparam int XS_SHIFT_B = 7;
    localparam int XS_SHIFT_C = 17;

    localparam logic [DATA_W-1:0] GEN_RESET = DATA_W'(1);

    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    localparam logic [1:0] WCODE_8  = 2'd0;
    localparam logic [1:0] WCODE_16 = 2'd1;
    localparam logic [1:0] WCODE_32 = 2'd2;
    localparam logic [1:0] WCODE_64 = 2'd3;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PREP,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic check;
        logic prep;
        logic div_step;
        logic fin;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_reseed;
        logic below;
    } t_dp_sts;

    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
        logic [DATA_W-1:0] m;
        unique case (code)
            WCODE_8:  m = DATA_W'(64'h0000_0000_0000_00FF);
            WCODE_16: m = DATA_W'(64'h0000_0000_0000_FFFF);
            WCODE_32: m = DATA_W'(64'h0000_0000_FFFF_FFFF);
            WCODE_64: m = '1;
            default:  m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] sign_bit(input logic [1:0] code);
        logic [DATA_W-1:0] b;
        unique case (code)
            WCODE_8:  b = DATA_W'(64'h0000_0000_0000_0080);
            WCODE_16: b = DATA_W'(64'h0000_0000_0000_8000);
            WCODE_32: b = DATA_W'(64'h0000_0000_8000_0000);
            WCODE_64: b = DATA_W'(64'h8000_0000_0000_0000);
            default:  b = DATA_W'(64'h8000_0000_0000_0000);
        endcase
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] xs_advance(input logic [DATA_W-1:0] s_in);
        logic [DATA_W-1:0] s;
        s = s_in;
        s = s ^ (s << XS_SHIFT_A);
        s = s ^ (s >> XS_SHIFT_B);
        s = s ^ (s << XS_SHIFT_C);
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/xrd_dpath.sv */
// Datapath: generator state, bound check, restoring remainder unit, result registers.
// Depends on xrd_pkg; driven by commands from xrd_ctrl.
`default_nettype none

module xrd_dpath import xrd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic              i_func,
    input  wire logic [SEED_W-1:0] i_seed_value,
    input  wire logic [DATA_W-1:0] i_low_bound,
    input  wire logic [DATA_W-1:0] i_high_bound,
    input  wire logic [1:0]        i_width_code,
    input  wire logic              i_is_signed,
    output logic      [DATA_W-1:0] o_value,
    output logic                   o_range_error
);

    logic [DATA_W-1:0] r_gen, n_gen;
    logic              r_func;
    logic [SEED_W-1:0] r_seed;
    logic [DATA_W-1:0] r_lo, r_hi;
    logic [1:0]        r_code;
    logic              r_sgn;
    logic [DATA_W-1:0] r_div;
    logic              r_full;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0] r_res;
    logic              r_err;
    logic [DATA_W-1:0] r_value;
    logic              r_range_error;

    logic [DATA_W-1:0] flip;
    logic              below;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;
    logic [DATA_W-1:0] fin_sel;

    always_comb begin
        flip    = r_sgn ? sign_bit(r_code) : '0;
        below   = (r_hi ^ flip) < (r_lo ^ flip);
        rem_sh  = {r_rem, r_dvd[DATA_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        fin_sel = r_full ? r_gen : r_rem;
        n_gen   = r_gen;
        if (i_cmd.check) begin
            if (r_func == FUNC_RESEED) begin
                n_gen = (r_seed == '0) ? GEN_RESET : DATA_W'(r_seed);
            end else if (!below) begin
                n_gen = xs_advance(r_gen);
            end
        end
    end

    assign o_sts.is_reseed = (r_func == FUNC_RESEED);
    assign o_sts.below     = below;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= GEN_RESET;
        end else begin
            r_gen <= n_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_seed <= i_seed_value;
            r_lo   <= i_low_bound & width_mask(i_width_code);
            r_hi   <= i_high_bound & width_mask(i_width_code);
            r_code <= i_width_code;
            r_sgn  <= i_is_signed;
        end
        if (i_cmd.check) begin
            r_div <= (r_hi - r_lo) & width_mask(r_code);
            r_res <= '0;
            r_err <= (r_func != FUNC_RESEED) && below;
        end
        if (i_cmd.prep) begin
            r_full <= (r_div == '1);
            r_div  <= r_div + DATA_W'(1);
            r_rem  <= '0;
            r_dvd  <= r_gen;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_sub[DATA_W] ? rem_sh[DATA_W-1:0] : rem_sub[DATA_W-1:0];
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
        end
        if (i_cmd.fin) begin
            r_res <= (r_lo + fin_sel) & width_mask(r_code);
            r_err <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_value       <= r_res;
            r_range_error <= r_err;
        end
    end

    assign o_value       = r_value;
    assign o_range_error = r_range_error;

endmodule

`default_nettype wire

/* rtl/core/xrd_ctrl.sv */
// Controller: sequences capture, check, 64-step remainder and result hand-off.
// Depends on xrd_pkg; drives xrd_dpath through t_dp_cmd.
`default_nettype none

module xrd_ctrl import xrd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = (i_sts.is_reseed || i_sts.below) ? S_DONE : S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CHECK))
        else $error("accepted transaction did not enter check");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != CNT_LAST)
            |=> (r_state == S_DIV && r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("remainder step count broken");

    a_load_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (r_state == S_DONE && (!r_out_valid || !i_out_stall)))
        else $error("result loaded over a pending transaction");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

/* rtl/core/xorshift64_range_draw_core.sv */
// Usage:
//   Input channel: i_in_valid / o_in_stall with fields i_func, i_seed_value,
//   i_low_bound, i_high_bound, i_width_code, i_is_signed. A transaction is taken
//   at a clock edge where i_in_valid is high and o_in_stall is low.
//   Output channel: o_out_valid / i_out_stall with fields o_value, o_range_error;
//   exactly one result transaction per input transaction, in order.
//   A reseed loads the 32-bit seed (zero becomes one) and returns zero.
//   A draw with high below low returns range_error and keeps the generator.
//   Otherwise the generator advances and low + state mod (span + 1) is returned.
//   A reseed or range error steps through S_CHECK and S_DONE to o_out_valid;
//   a draw through S_CHECK, S_PREP, S_DIV, S_FIN and S_DONE, where S_DIV runs
//   the bit-serial restoring remainder unit, one dividend bit per cycle.
//   One transaction is worked on at a time.
//   The result sits in an output register, so the next transaction is accepted
//   while a finished result waits under i_out_stall; a later result waits in
//   the datapath until the output register frees up.
//   Reset (i_rst_n low, synchronous) sets the generator state to one and
//   empties the output register.
// Depends on xrd_pkg, xrd_ctrl, xrd_dpath.
`default_nettype none

module xorshift64_range_draw_core import xrd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_func,
    input  wire logic [SEED_W-1:0] i_seed_value,
    input  wire logic [DATA_W-1:0] i_low_bound,
    input  wire logic [DATA_W-1:0] i_high_bound,
    input  wire logic [1:0]        i_width_code,
    input  wire logic              i_is_signed,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [DATA_W-1:0] o_value,
    output logic                   o_range_error
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    xrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    xrd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_seed_value  (i_seed_value),
        .i_low_bound   (i_low_bound),
        .i_high_bound  (i_high_bound),
        .i_width_code  (i_width_code),
        .i_is_signed   (i_is_signed),
        .o_value       (o_value),
        .o_range_error (o_range_error)
    );

endmodule

`default_nettype wire
